>>> rtl/pwmdw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmdw_pkg
// Shared widths, constants and types of the pwm divider and wrap calculator.
// ----------------------------------------------------------------------------
package pwmdw_pkg;

    localparam int FREQ_W   = 28;
    localparam int CLK_W    = 28;
    localparam int DUTY_W   = 8;
    localparam int SLICE_W  = 3;

    // input tdata: freq, duty; input tuser: slice, channel
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 4;
    // output tdata: div int, div frac, top, compare, out of range
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 4;

    localparam logic [CLK_W-1:0] CLK_RESET = 28'd125000000;

    // first divider: (clk >> 12) / freq, one quotient bit a stage
    localparam int D1_BITS  = 16;
    // second divider: (clk * 16) / (div16 * freq), saturating quotient
    localparam int D2_BITS  = 17;
    localparam int D2_DEN_W = 40;

    localparam logic [11:0] DIV16_MAX = 12'd4095;
    localparam logic [11:0] DIV16_ONE = 12'd16;
    localparam logic [15:0] TOP_MAX   = 16'hFFFF;
    localparam logic [16:0] RECIP_255 = 17'h10101;
    localparam logic [7:0]  FULL_DUTY = 8'd255;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [SLICE_W-1:0] pwm_slice;
        logic               pwm_channel;
    } t_side;

endpackage

>>> rtl/pwm_divider_wrap_calculator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_divider_wrap_calculator_unit
// Turns a pwm frequency and duty into an 8.4 clock divider, counter top and
// compare level, through a fully pipelined pair of restoring dividers.
// ----------------------------------------------------------------------------
// channel   dir  tdata                               tuser
// s_axis    in   freq[27:0] duty[35:28]              slice[2:0] channel[3]
// m_axis    out  div_int[7:0] div_frac[11:8]         slice[2:0] channel[3]
//                top[27:12] compare[43:28] oor[44]
// cfg       in   source clock in hz, 28 bits
//
// one item enters each cycle while no stall holds the pipeline; an item passes
// 41 registers: input register,
// 16 quotient stages of the divider step, clamp, product, overflow check,
// 17 stages of the top division, top, multiply, reciprocal and output.
// all stages advance together whenever the output register is empty or
// taken, so a stall holds every item in place. reset clears valid bits
// and loads the source clock with 125 MHz.
// ----------------------------------------------------------------------------
module pwm_divider_wrap_calculator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pwmdw_pkg::CLK_W-1:0]       i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [pwmdw_pkg::S_DATA_W-1:0]    i_s_axis_tdata,  // freq, duty
    input  logic [pwmdw_pkg::S_USER_W-1:0]    i_s_axis_tuser,  // slice, channel
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [pwmdw_pkg::M_DATA_W-1:0]    o_m_axis_tdata,  // int, frac, top, cmp, oor
    output logic [pwmdw_pkg::M_USER_W-1:0]    o_m_axis_tuser   // slice, channel
);
    import pwmdw_pkg::*;

    logic en;
    logic [CLK_W-1:0] r_clk_hz;

    // first divider pipeline, index 0 is the input register
    logic               r_d1_v    [0:D1_BITS];
    logic [FREQ_W-1:0]  r_d1_rem  [0:D1_BITS];
    logic [D1_BITS-1:0] r_d1_q    [0:D1_BITS];
    logic [FREQ_W-1:0]  r_d1_freq [0:D1_BITS];
    logic [CLK_W-1:0]   r_d1_clk  [0:D1_BITS];
    t_side              r_d1_side [0:D1_BITS];

    // divider clamp stage
    logic              r_b_v, r_b_fz, r_b_flag;
    logic [11:0]       r_b_div16;
    logic [FREQ_W-1:0] r_b_freq;
    logic [CLK_W-1:0]  r_b_clk;
    t_side             r_b_side;

    // denominator product stage
    logic                r_c_v, r_c_fz, r_c_flag;
    logic [11:0]         r_c_div16;
    logic [D2_DEN_W-1:0] r_c_den;
    logic [31:0]         r_c_num;
    t_side               r_c_side;

    // second divider pipeline, index 0 holds the overflow check
    logic                r_d2_v    [0:D2_BITS];
    logic [D2_DEN_W-1:0] r_d2_rem  [0:D2_BITS];
    logic [D2_BITS-1:0]  r_d2_q    [0:D2_BITS];
    logic [D2_DEN_W-1:0] r_d2_den  [0:D2_BITS];
    logic [31:0]         r_d2_num  [0:D2_BITS];
    logic                r_d2_ovf  [0:D2_BITS];
    logic                r_d2_fz   [0:D2_BITS];
    logic                r_d2_flag [0:D2_BITS];
    logic [11:0]         r_d2_div  [0:D2_BITS];
    t_side               r_d2_side [0:D2_BITS];

    // top, product, reciprocal and output stages
    logic        r_e_v, r_e_flag;
    logic [15:0] r_e_top;
    logic [11:0] r_e_div;
    t_side       r_e_side;

    logic        r_f_v, r_f_flag;
    logic [15:0] r_f_top;
    logic [23:0] r_f_x;
    logic [11:0] r_f_div;
    t_side       r_f_side;

    logic        r_g_v, r_g_flag;
    logic [15:0] r_g_top;
    logic [23:0] r_g_x;
    logic [16:0] r_g_q;
    logic [11:0] r_g_div;
    t_side       r_g_side;

    logic        r_o_v, r_o_flag;
    logic [15:0] r_o_top, r_o_cmp;
    logic [11:0] r_o_div;
    t_side       r_o_side;

    logic [16:0] n_b_sum;
    logic [11:0] n_b_div;
    logic        n_b_flag;
    logic [15:0] n_e_top;
    logic        n_e_flag;
    logic [40:0] n_g_prod;
    logic [24:0] n_h_rem;

    assign en              = !r_o_v || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= CLK_RESET;
        end else if (i_cfg_we) begin
            r_clk_hz <= i_cfg_wdata;
        end
    end

    // valid bits of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= D1_BITS; k++) r_d1_v[k] <= 1'b0;
            for (int k = 0; k <= D2_BITS; k++) r_d2_v[k] <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r_d1_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k <= D1_BITS; k++) r_d1_v[k] <= r_d1_v[k-1];
            r_b_v     <= r_d1_v[D1_BITS];
            r_c_v     <= r_b_v;
            r_d2_v[0] <= r_c_v;
            for (int k = 1; k <= D2_BITS; k++) r_d2_v[k] <= r_d2_v[k-1];
            r_e_v <= r_d2_v[D2_BITS];
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_o_v <= r_g_v;
        end
    end

    // first divider: floor((clk >> 12) / freq), one bit a stage
    always_ff @(posedge i_clk) begin
        logic [FREQ_W:0] t;
        if (en) begin
            r_d1_rem[0]  <= '0;
            r_d1_q[0]    <= '0;
            r_d1_freq[0] <= i_s_axis_tdata[FREQ_W-1:0];
            r_d1_clk[0]  <= r_clk_hz;
            r_d1_side[0] <= '{duty:        i_s_axis_tdata[FREQ_W+DUTY_W-1:FREQ_W],
                              pwm_slice:   i_s_axis_tuser[SLICE_W-1:0],
                              pwm_channel: i_s_axis_tuser[SLICE_W]};
            for (int k = 1; k <= D1_BITS; k++) begin
                t = {r_d1_rem[k-1], r_d1_clk[k-1][12 + D1_BITS - k]};
                if (t >= {1'b0, r_d1_freq[k-1]}) begin
                    r_d1_rem[k] <= FREQ_W'(t - {1'b0, r_d1_freq[k-1]});
                    r_d1_q[k]   <= {r_d1_q[k-1][D1_BITS-2:0], 1'b1};
                end else begin
                    r_d1_rem[k] <= t[FREQ_W-1:0];
                    r_d1_q[k]   <= {r_d1_q[k-1][D1_BITS-2:0], 1'b0};
                end
                r_d1_freq[k] <= r_d1_freq[k-1];
                r_d1_clk[k]  <= r_d1_clk[k-1];
                r_d1_side[k] <= r_d1_side[k-1];
            end
        end
    end

    // round the divider up and clamp it to 1.0 .. 255 + 15/16
    always_comb begin
        n_b_sum = {1'b0, r_d1_q[D1_BITS]}
                + 17'((r_d1_rem[D1_BITS] != '0) || (r_d1_clk[D1_BITS][11:0] != '0));
        n_b_flag = 1'b0;
        if (r_d1_freq[D1_BITS] == '0) begin
            n_b_div  = DIV16_MAX;
            n_b_flag = 1'b1;
        end else if (n_b_sum[16:4] == '0) begin
            n_b_div = DIV16_ONE;
        end else if (n_b_sum[16:12] != '0) begin
            n_b_div  = DIV16_MAX;
            n_b_flag = 1'b1;
        end else begin
            n_b_div = n_b_sum[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_fz    <= (r_d1_freq[D1_BITS] == '0);
            r_b_flag  <= n_b_flag;
            r_b_div16 <= n_b_div;
            r_b_freq  <= r_d1_freq[D1_BITS];
            r_b_clk   <= r_d1_clk[D1_BITS];
            r_b_side  <= r_d1_side[D1_BITS];
        end
    end

    // denominator div16 * freq and numerator clk * 16
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_fz    <= r_b_fz;
            r_c_flag  <= r_b_flag;
            r_c_div16 <= r_b_div16;
            r_c_den   <= D2_DEN_W'(r_b_div16) * D2_DEN_W'(r_b_freq);
            r_c_num   <= {r_b_clk, 4'b0000};
            r_c_side  <= r_b_side;
        end
    end

    // second divider: overflow check, then one quotient bit a stage
    always_ff @(posedge i_clk) begin
        logic [D2_DEN_W:0] t;
        if (en) begin
            r_d2_ovf[0]  <= {25'd0, r_c_num[31:D2_BITS]} >= r_c_den;
            r_d2_rem[0]  <= D2_DEN_W'(r_c_num[31:D2_BITS]);
            r_d2_q[0]    <= '0;
            r_d2_den[0]  <= r_c_den;
            r_d2_num[0]  <= r_c_num;
            r_d2_fz[0]   <= r_c_fz;
            r_d2_flag[0] <= r_c_flag;
            r_d2_div[0]  <= r_c_div16;
            r_d2_side[0] <= r_c_side;
            for (int k = 1; k <= D2_BITS; k++) begin
                t = {r_d2_rem[k-1], r_d2_num[k-1][D2_BITS - k]};
                if (t >= {1'b0, r_d2_den[k-1]}) begin
                    r_d2_rem[k] <= D2_DEN_W'(t - {1'b0, r_d2_den[k-1]});
                    r_d2_q[k]   <= {r_d2_q[k-1][D2_BITS-2:0], 1'b1};
                end else begin
                    r_d2_rem[k] <= t[D2_DEN_W-1:0];
                    r_d2_q[k]   <= {r_d2_q[k-1][D2_BITS-2:0], 1'b0};
                end
                r_d2_den[k]  <= r_d2_den[k-1];
                r_d2_num[k]  <= r_d2_num[k-1];
                r_d2_ovf[k]  <= r_d2_ovf[k-1];
                r_d2_fz[k]   <= r_d2_fz[k-1];
                r_d2_flag[k] <= r_d2_flag[k-1];
                r_d2_div[k]  <= r_d2_div[k-1];
                r_d2_side[k] <= r_d2_side[k-1];
            end
        end
    end

    // top = quotient - 1 with clamps
    always_comb begin
        n_e_flag = r_d2_flag[D2_BITS];
        if (r_d2_fz[D2_BITS]) begin
            n_e_top  = TOP_MAX;
            n_e_flag = 1'b1;
        end else if (r_d2_ovf[D2_BITS]) begin
            // quotient does not fit in the quotient bits
            n_e_top  = TOP_MAX;
            n_e_flag = 1'b1;
        end else if (r_d2_q[D2_BITS] == '0) begin
            n_e_top  = '0;
            n_e_flag = 1'b1;
        end else if (r_d2_q[D2_BITS] > 17'h10000) begin
            n_e_top  = TOP_MAX;
            n_e_flag = 1'b1;
        end else begin
            n_e_top = 16'(r_d2_q[D2_BITS] - 17'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_top  <= n_e_top;
            r_e_flag <= n_e_flag;
            r_e_div  <= r_d2_div[D2_BITS];
            r_e_side <= r_d2_side[D2_BITS];
        end
    end

    // top * duty
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_x    <= 24'(r_e_top) * 24'(r_e_side.duty);
            r_f_top  <= r_e_top;
            r_f_flag <= r_e_flag;
            r_f_div  <= r_e_div;
            r_f_side <= r_e_side;
        end
    end

    // estimate of x / 255 by reciprocal, low by at most one
    assign n_g_prod = 41'(r_f_x) * 41'(RECIP_255);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_q    <= n_g_prod[40:24];
            r_g_x    <= r_f_x;
            r_g_top  <= r_f_top;
            r_g_flag <= r_f_flag;
            r_g_div  <= r_f_div;
            r_g_side <= r_f_side;
        end
    end

    // remainder correction and output register
    assign n_h_rem = {1'b0, r_g_x} - 25'(r_g_q) * 25'(FULL_DUTY);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_cmp  <= (n_h_rem >= 25'(FULL_DUTY)) ? 16'(r_g_q + 17'd1) : r_g_q[15:0];
            r_o_top  <= r_g_top;
            r_o_flag <= r_g_flag;
            r_o_div  <= r_g_div;
            r_o_side <= r_g_side;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {3'b000, r_o_flag, r_o_cmp, r_o_top, r_o_div[3:0], r_o_div[11:4]};
    assign o_m_axis_tuser  = {r_o_side.pwm_channel, r_o_side.pwm_slice};

endmodule

>>> rtl/pwmdw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmdw_checker
// Port-level checks of the pwm divider and wrap calculator, bound to the top.
// ----------------------------------------------------------------------------
module pwmdw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [pwmdw_pkg::M_DATA_W-1:0] o_m_axis_tdata
);
    import pwmdw_pkg::*;

    // a waiting result item stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result item dropped while stalled");

    // input side stalls only behind a stalled full output register
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output stall");

    // divider integer part is never zero
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:0] != 8'd0)
        else $error("divider integer part is zero");

    // compare level never exceeds the top
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[43:28] <= o_m_axis_tdata[27:12])
        else $error("compare level above counter top");

endmodule

bind pwm_divider_wrap_calculator_unit pwmdw_checker u_pwmdw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
